// File: hdl/q8_q4_block_dot_accumulator_unit_defines.svh
// ----------------------------------------------------------------------------
// q8_q4_block_dot_accumulator_unit_defines
// assertion macros used by the checker of the dot accumulator
// ----------------------------------------------------------------------------
`ifndef Q8_Q4_BLOCK_DOT_ACCUMULATOR_UNIT_DEFINES_SVH
`define Q8_Q4_BLOCK_DOT_ACCUMULATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define Q8Q4DA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define Q8Q4DA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/q8q4da_pkg.sv
// ----------------------------------------------------------------------------
// q8q4da_pkg
// types, widths and constants of the q8 x q4 block dot accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package q8q4da_pkg;

	localparam int BLOCK_ELEMS = 32;
	localparam int MAX_BLOCKS  = 256;
	localparam int HALF_ELEMS  = BLOCK_ELEMS / 2;

	localparam int BYTE_W    = 8;
	localparam int NIB_W     = 4;
	localparam int NIB_OFFSET = 8;
	localparam int ACT_BITS  = BLOCK_ELEMS * BYTE_W;
	localparam int WT_BITS   = HALF_ELEMS * BYTE_W;
	localparam int IDX_W     = $clog2(HALF_ELEMS);
	localparam int ACT_IDX_W = $clog2(BLOCK_ELEMS);

	localparam int SCALE_IN_W = 16;
	localparam int SCALE_W    = 2 * SCALE_IN_W;
	localparam int WNIB_W     = NIB_W + 1;
	localparam int PROD_W     = BYTE_W + WNIB_W;
	localparam int DOT_W      = 17;
	localparam int TERM_W     = DOT_W + SCALE_W;
	localparam int SUM_W      = 56;

	typedef struct packed {
		logic [63:0]                   act_bytes_0;
		logic [63:0]                   act_bytes_1;
		logic [63:0]                   act_bytes_2;
		logic [63:0]                   act_bytes_3;
		logic [63:0]                   weight_bytes_0;
		logic [63:0]                   weight_bytes_1;
		logic signed [SCALE_IN_W-1:0]  act_scale;
		logic signed [SCALE_IN_W-1:0]  weight_scale;
		logic                          last_block;
	} blk_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] dot_sum;
		logic                    overflowed;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_TERM,
		ST_ACC
	} state_t;

	typedef struct packed {
		logic             load;
		logic             mac;
		logic [IDX_W-1:0] idx;
		logic             term;
		logic             acc;
		logic             emit;
	} cmd_t;

endpackage

`default_nettype wire

// File: hdl/q8q4da_dpath.sv
// ----------------------------------------------------------------------------
// q8q4da_dpath
// block registers, two-lane multiply-accumulate, scale product and
// saturating running sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module q8q4da_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  q8q4da_pkg::blk_t  blk,
	input  q8q4da_pkg::cmd_t  cmd,
	output q8q4da_pkg::res_t  res
);
	import q8q4da_pkg::*;

	logic [ACT_BITS-1:0]        act_q;
	logic [WT_BITS-1:0]         wt_q;
	logic signed [SCALE_W-1:0]  scale_q;
	logic signed [DOT_W-1:0]    dot_q;
	logic signed [TERM_W-1:0]   term_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       sat_q;
	res_t                       res_q;

	logic [ACT_IDX_W-1:0]       hi_idx;
	logic signed [BYTE_W-1:0]   act_lo;
	logic signed [BYTE_W-1:0]   act_hi;
	logic [BYTE_W-1:0]          wbyte;
	logic signed [WNIB_W-1:0]   nib_lo;
	logic signed [WNIB_W-1:0]   nib_hi;
	logic signed [PROD_W-1:0]   prod_lo;
	logic signed [PROD_W-1:0]   prod_hi;
	logic signed [SUM_W:0]      sum_ext;
	logic signed [SUM_W-1:0]    sum_next;
	logic                       ovf;

	// lane pair: element q and element q plus half block
	assign hi_idx  = {1'b0, cmd.idx} + ACT_IDX_W'(HALF_ELEMS);
	assign act_lo  = act_q[cmd.idx*BYTE_W +: BYTE_W];
	assign act_hi  = act_q[hi_idx*BYTE_W +: BYTE_W];
	assign wbyte   = wt_q[cmd.idx*BYTE_W +: BYTE_W];
	assign nib_lo  = $signed({1'b0, wbyte[NIB_W-1:0]}) - WNIB_W'(NIB_OFFSET);
	assign nib_hi  = $signed({1'b0, wbyte[BYTE_W-1:NIB_W]}) - WNIB_W'(NIB_OFFSET);
	assign prod_lo = act_lo * nib_lo;
	assign prod_hi = act_hi * nib_hi;

	// saturating add into the running sum
	always_comb begin
		sum_ext = {sum_q[SUM_W-1], sum_q} + (SUM_W+1)'(term_q);
		ovf     = sum_ext[SUM_W] != sum_ext[SUM_W-1];
		if (!ovf) begin
			sum_next = sum_ext[SUM_W-1:0];
		end else if (sum_ext[SUM_W]) begin
			sum_next = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sum_next = {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= {blk.act_bytes_3, blk.act_bytes_2, blk.act_bytes_1, blk.act_bytes_0};
			wt_q    <= {blk.weight_bytes_1, blk.weight_bytes_0};
			scale_q <= blk.act_scale * blk.weight_scale;
			dot_q   <= '0;
		end else if (cmd.mac) begin
			dot_q <= dot_q + DOT_W'(prod_lo) + DOT_W'(prod_hi);
		end
		if (cmd.term) begin
			term_q <= dot_q * scale_q;
		end
		if (cmd.emit) begin
			res_q.dot_sum    <= sum_next;
			res_q.overflowed <= sat_q | ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.acc) begin
			if (cmd.emit) begin
				sum_q <= '0;
				sat_q <= 1'b0;
			end else begin
				sum_q <= sum_next;
				sat_q <= sat_q | ovf;
			end
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// File: hdl/q8q4da_ctrl.sv
// ----------------------------------------------------------------------------
// q8q4da_ctrl
// sequencer: block capture, lane steps, scaling, accumulate and result slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module q8q4da_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              blk_valid,
	input  logic              last_block,
	output logic              blk_stall,
	input  logic              res_stall,
	output logic              res_valid,
	output q8q4da_pkg::cmd_t  cmd
);
	import q8q4da_pkg::*;

	state_t           state_q;
	state_t           state_nxt;
	logic [IDX_W-1:0] cnt_q;
	logic             last_q;
	logic             res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				cnt_q  <= '0;
				last_q <= last_block;
			end else if (cmd.mac) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.idx   = cnt_q;
		blk_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				blk_stall = 1'b0;
				if (blk_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_MAC;
				end
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				if (cnt_q == IDX_W'(HALF_ELEMS - 1)) begin
					state_nxt = ST_TERM;
				end
			end
			ST_TERM: begin
				cmd.term  = 1'b1;
				state_nxt = ST_ACC;
			end
			ST_ACC: begin
				if (!last_q) begin
					cmd.acc   = 1'b1;
					state_nxt = ST_IDLE;
				end else if (!res_valid_q || !res_stall) begin
					cmd.acc   = 1'b1;
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

// File: hdl/q8_q4_block_dot_accumulator_unit.sv
// sequence: a block is captured, then goes through the lane steps, the scaling step and the
//   accumulate step; on a last block the result is offered from the cycle after that step, or later
//   while an earlier result still waits in the result register
// a new block is taken only once the previous one has passed the capture cycle, the 16 steps of
//   the two-lane multiply-accumulate, one scaling multiply and one accumulate step
// reset: arst_n clears the running sum, the sticky saturation flag and all control
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// q8_q4_block_dot_accumulator_unit
// q8 activation x q4 weight block dot product with scaled, saturating
// accumulation over a stream of blocks
// ----------------------------------------------------------------------------

module q8_q4_block_dot_accumulator_unit (
	input  logic              clk,
	input  logic              arst_n,
	// block channel, a transfer when blk_valid is high and blk_stall low
	input  logic              blk_valid,
	output logic              blk_stall,
	input  q8q4da_pkg::blk_t  blk,
	// result channel, one transfer per last block
	output logic              res_valid,
	input  logic              res_stall,
	output q8q4da_pkg::res_t  res
);
	import q8q4da_pkg::*;

	cmd_t cmd;

	// sequencer: takes a block only when idle, then walks the lane steps.
	// the result register is separate, so a waiting result does not hold
	// off the next block; only a second last block waits for the slot
	q8q4da_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_valid  (blk_valid),
		.last_block (blk.last_block),
		.blk_stall  (blk_stall),
		.res_stall  (res_stall),
		.res_valid  (res_valid),
		.cmd        (cmd)
	);

	// datapath: the scale product is formed as the block is captured,
	// element pairs q and q+16 share one weight byte per step, and the
	// 49-bit term is added into the 56-bit sum with clamping to the limits
	q8q4da_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.blk    (blk),
		.cmd    (cmd),
		.res    (res)
	);

endmodule

`default_nettype wire

// File: hdl/q8q4da_chk.sv
// ----------------------------------------------------------------------------
// q8q4da_chk
// port-level checks of the dot accumulator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "q8_q4_block_dot_accumulator_unit_defines.svh"

module q8q4da_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              blk_valid,
	input logic              blk_stall,
	input q8q4da_pkg::blk_t  blk,
	input logic              res_valid,
	input logic              res_stall,
	input q8q4da_pkg::res_t  res
);
	import q8q4da_pkg::*;

	logic blk_xfer;
	logic last_xfer;

	assign blk_xfer  = blk_valid && !blk_stall;
	assign last_xfer = blk_xfer && blk.last_block;

	// a stalled result holds still
	`Q8Q4DA_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result changed while stalled")

	// the block is busy for the cycle after every block transfer
	`Q8Q4DA_ASSERT_NEXT(a_busy_after_xfer, blk_xfer, blk_stall, "block taken back to back")

	// a new result only appears at the end of work on a block
	`Q8Q4DA_ASSERT_NOW(a_res_from_work, $rose(res_valid), $past(blk_stall), "result without a block in work")

	// a last block never produces its result in the very next cycle
	`Q8Q4DA_ASSERT_NEXT(a_no_instant_res, last_xfer && !res_valid, !res_valid, "result too early")

endmodule

bind q8_q4_block_dot_accumulator_unit q8q4da_chk u_chk (.*);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// testbench
// drives quantization blocks into the q8 x q4 dot accumulator with random
// gaps and result stalls, predicts each emitted sum and overflow flag from
// the block contents, and checks every result transfer in order
// ----------------------------------------------------------------------------

module testbench;

	import q8q4da_pkg::*;

	// saturation limits of the 56-bit running sum
	localparam longint SUM_HI = 64'sh007F_FFFF_FFFF_FFFF;
	localparam longint SUM_LO = -SUM_HI - 64'sd1;

	// scale codes used by the directed parts
	localparam logic signed [SCALE_IN_W-1:0] SC_MIN = 16'sh8000;
	localparam logic signed [SCALE_IN_W-1:0] SC_MAX = 16'sh7fff;
	localparam logic signed [SCALE_IN_W-1:0] SC_ONE = 16'sd4096;

	logic clk;
	logic arst_n;
	logic blk_valid;
	logic blk_stall;
	blk_t blk;
	logic res_valid;
	logic res_stall;
	res_t res;

	// predictor state: running sum and sticky saturation flag
	longint acc_sum;
	bit     acc_sat;
	res_t   pending_sums[$];
	res_t   want_res;

	// idling controls, one per side
	bit tx_idle;
	bit rx_idle;
	int rx_wait;
	int hold_cycles;
	int fails;

	q8_q4_block_dot_accumulator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.blk       (blk),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#8_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// exact scaled term of one block: 32-lane integer dot times scale product
	function automatic longint block_term(blk_t b);
		logic [ACT_BITS-1:0] acts;
		logic [WT_BITS-1:0]  wts;
		logic [BYTE_W-1:0]   wb;
		int                  dot;
		int                  q;
		longint              scl;
		acts = {b.act_bytes_3, b.act_bytes_2, b.act_bytes_1, b.act_bytes_0};
		wts  = {b.weight_bytes_1, b.weight_bytes_0};
		dot  = 0;
		for (q = 0; q < HALF_ELEMS; q++) begin
			wb = wts[q*BYTE_W +: BYTE_W];
			// low nibble pairs with element q, high nibble with element q+16
			dot += $signed(acts[q*BYTE_W +: BYTE_W]) * (int'(wb[3:0]) - NIB_OFFSET);
			dot += $signed(acts[(q+HALF_ELEMS)*BYTE_W +: BYTE_W])
				* (int'(wb[7:4]) - NIB_OFFSET);
		end
		scl = longint'(b.act_scale) * longint'(b.weight_scale);
		return longint'(dot) * scl;
	endfunction

	// fold one accepted block into the predicted sum, queue a result on the last one
	function automatic void fold_block(blk_t b);
		longint nxt;
		res_t   r;
		nxt = acc_sum + block_term(b);
		if (nxt > SUM_HI) begin
			nxt     = SUM_HI;
			acc_sat = 1'b1;
		end else if (nxt < SUM_LO) begin
			nxt     = SUM_LO;
			acc_sat = 1'b1;
		end
		acc_sum = nxt;
		if (b.last_block) begin
			r.dot_sum    = acc_sum[SUM_W-1:0];
			r.overflowed = acc_sat;
			pending_sums.push_back(r);
			acc_sum = 0;
			acc_sat = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------
	// block builders
	// ------------------------------------------------------------------

	function automatic blk_t mk_block(input logic [ACT_BITS-1:0] acts,
		input logic [WT_BITS-1:0] wts, input logic signed [SCALE_IN_W-1:0] a_sc,
		input logic signed [SCALE_IN_W-1:0] w_sc, input logic last);
		blk_t b;
		b.act_bytes_0    = acts[63:0];
		b.act_bytes_1    = acts[127:64];
		b.act_bytes_2    = acts[191:128];
		b.act_bytes_3    = acts[255:192];
		b.weight_bytes_0 = wts[63:0];
		b.weight_bytes_1 = wts[127:64];
		b.act_scale      = a_sc;
		b.weight_scale   = w_sc;
		b.last_block     = last;
		return b;
	endfunction

	// bytes lean towards the int8 and nibble extremes
	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		int          i;
		for (i = 0; i < 8; i++) begin
			case ($urandom_range(0, 7))
				0: w[i*8 +: 8] = 8'h80;
				1: w[i*8 +: 8] = 8'h7f;
				2: w[i*8 +: 8] = 8'h00;
				3: w[i*8 +: 8] = 8'hff;
				4: w[i*8 +: 8] = 8'h88;
				default: w[i*8 +: 8] = 8'($urandom);
			endcase
		end
		return w;
	endfunction

	function automatic logic signed [SCALE_IN_W-1:0] rand_scale();
		case ($urandom_range(0, 5))
			0: return SC_MIN;
			1: return SC_MAX;
			2: return '0;
			3: return SC_ONE;
			default: return SCALE_IN_W'($urandom);
		endcase
	endfunction

	function automatic blk_t rand_block(logic last);
		return mk_block({rand_word(), rand_word(), rand_word(), rand_word()},
			{rand_word(), rand_word()}, rand_scale(), rand_scale(), last);
	endfunction

	// ------------------------------------------------------------------
	// block channel driver
	// ------------------------------------------------------------------

	// offer one block after a random gap and wait for its transfer
	task automatic send_block(input blk_t b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			blk_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		blk_valid <= 1'b1;
		blk       <= b;
		do @(posedge clk); while (blk_stall);
		fold_block(b);
	endtask

	// ------------------------------------------------------------------
	// result channel: stall control and checking
	// ------------------------------------------------------------------

	// long hold-offs take priority over the per-result random stall
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_sums.size() == 0) begin
				$error("result transfer with nothing pending: dot_sum %0d overflowed %0b",
					res.dot_sum, res.overflowed);
				fails++;
			end else begin
				want_res = pending_sums.pop_front();
				if (res.dot_sum !== want_res.dot_sum) begin
					$error("dot_sum: expected %0d, got %0d", want_res.dot_sum, res.dot_sum);
					fails++;
				end
				if (res.overflowed !== want_res.overflowed) begin
					$error("overflowed: expected %0b, got %0b",
						want_res.overflowed, res.overflowed);
					fails++;
				end
			end
			// stall drawn for the run-up to the next result
			rx_wait = rx_idle ? $urandom_range(0, 10) : 0;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// field extremes, lane mapping of both nibbles and multi-block sums
	task automatic test_directed();
		send_block(mk_block('0, '0, '0, '0, 1'b1));
		// largest positive term: -128 * -8 on every lane, scale product 2^30
		send_block(mk_block({32{8'h80}}, {16{8'h00}}, SC_MIN, SC_MIN, 1'b1));
		// most negative dot with largest positive scales
		send_block(mk_block({32{8'h7f}}, {16{8'h00}}, SC_MAX, SC_MAX, 1'b1));
		// nibble 7 against -128 with a mixed-sign scale
		send_block(mk_block({32{8'h80}}, {16{8'hff}}, SC_MIN, SC_MAX, 1'b1));
		// element 0 on the low nibble of weight byte 0
		send_block(mk_block(256'h1, {{15{8'h88}}, 8'h89}, SC_ONE, SC_ONE, 1'b1));
		// element 16 on the high nibble of weight byte 0
		send_block(mk_block({64'h0, 64'h1, 128'h0}, {{15{8'h88}}, 8'ha8},
			SC_ONE, SC_ONE, 1'b1));
		// element 15 on the low nibble of weight byte 15
		send_block(mk_block({128'h0, 8'h7f, 120'h0}, {8'h8f, {15{8'h88}}},
			SC_ONE, SC_ONE, 1'b1));
		// element 31 on the high nibble of weight byte 15
		send_block(mk_block({8'h80, 248'h0}, {8'h08, {15{8'h88}}}, SC_ONE, SC_MIN, 1'b1));
		// zero scale hides a non-zero dot
		send_block(mk_block({32{8'h80}}, {16{8'h00}}, '0, SC_MAX, 1'b1));
		// all-ones bytes everywhere
		send_block(mk_block({32{8'hff}}, {16{8'hff}}, 16'shffff, 16'shffff, 1'b1));
		// a four-block dot product: nothing comes out until the last block
		send_block(mk_block({32{8'h80}}, {16{8'h00}}, SC_ONE, SC_ONE, 1'b0));
		send_block(mk_block({32{8'h7f}}, {16{8'hff}}, SC_MAX, SC_MIN, 1'b0));
		send_block(mk_block({32{8'h01}}, {16{8'h99}}, SC_ONE, 16'sh0001, 1'b0));
		send_block(mk_block({32{8'h55}}, {16{8'h3c}}, 16'sh1234, 16'shedcb, 1'b1));
		// a short sum after the long one must start from zero
		send_block(mk_block({32{8'h02}}, {16{8'h9a}}, SC_ONE, SC_ONE, 1'b1));
	endtask

	// run the sum into the top limit and pull it back; the flag sticks until the emit
	task automatic test_saturation();
		int k;
		// 1024 largest terms already reach past the top limit
		for (k = 0; k < 1026; k++)
			send_block(mk_block({32{8'h80}}, {16{8'h00}}, SC_MIN, SC_MIN, 1'b0));
		// pull back below the limit: flag stays set
		for (k = 0; k < 3; k++)
			send_block(mk_block({32{8'h80}}, {16{8'h00}}, SC_MIN, SC_MAX, 1'b0));
		send_block(mk_block({32{8'h80}}, {16{8'h00}}, SC_MIN, SC_MIN, 1'b1));
		// flag must be clear for the next dot product
		send_block(rand_block(1'b1));
	endtask

	// receiver holds off for a long stretch while blocks keep coming
	task automatic test_backpressure();
		int k;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		@(posedge clk);
		hold_cycles = 300;
		for (k = 0; k < 30; k++)
			send_block(rand_block(k[0]));
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// random dot products, mostly short, now and then up to the longest
	task automatic test_random();
		int items;
		int len;
		int k;
		items = 0;
		while (items < 620) begin
			// change the idling mix now and then, including idle-free stretches
			if ($urandom_range(0, 7) == 0) begin
				tx_idle = ($urandom_range(0, 3) != 0);
				rx_idle = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 39) == 0)
				len = $urandom_range(1, MAX_BLOCKS);
			else
				len = $urandom_range(1, 8);
			for (k = 0; k < len; k++)
				send_block(rand_block(k == len - 1));
			items += len;
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n      = 1'b0;
		blk_valid   = 1'b0;
		blk         = '0;
		tx_idle     = 1'b1;
		rx_idle     = 1'b1;
		rx_wait     = 0;
		hold_cycles = 0;
		fails       = 0;
		acc_sum     = 0;
		acc_sat     = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_saturation();
		test_backpressure();
		test_random();

		@(negedge clk);
		blk_valid <= 1'b0;
		// drain, then give the block time to show any stray result
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
